/* rtl/core/point_in_triangle_area_test_core_defines.svh */
// Assertion macros for the checker file (pitat_chk).
`ifndef POINT_IN_TRIANGLE_AREA_TEST_CORE_DEFINES_SVH
`define POINT_IN_TRIANGLE_AREA_TEST_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PITAT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define PITAT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/pitat_pkg.sv */
`default_nettype none
package pitat_pkg;

   localparam int COORD_BITS = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = COORD_BITS;
   localparam int TOL_W      = 8;
   localparam int TRI_W      = 24;
   localparam int SUM_W      = 26;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_A_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_A_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_B_X   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_B_Y   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_C_X   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_C_Y   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_TOL     = 3'd6;
   localparam logic [TOL_W-1:0]     TOL_RESET        = 8'd5;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
   } req_payload_type;

   typedef struct packed {
      logic             inside_res;
      logic [TRI_W-1:0] triangle_area;
      logic [SUM_W-1:0] summed_area;
   } rsp_payload_type;

   // side length width, Q.frac
   function automatic int side_w(input int frac);
      return COORD_BITS + 1 + frac;
   endfunction

   // Heron area width, Q.2*frac
   function automatic int area_w(input int frac);
      return 2 * (side_w(frac) + 1);
   endfunction

   // register stages from heron inputs to area output
   function automatic int heron_lat(input int frac);
      return 3 * side_w(frac) + 9;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/pitat_isqrt.sv */
`default_nettype none
module pitat_isqrt
   import pitat_pkg::*;
#(
   parameter int IN_W = 34
) (
   input  wire logic                    clock,
   input  wire logic                    en,
   input  wire logic [IN_W-1:0]         rad_i,
   output logic      [(IN_W+1)/2-1:0]   root_o
);

   localparam int OUT_W = (IN_W + 1) / 2;
   localparam int PAD_W = 2 * OUT_W;
   localparam int REM_W = OUT_W + 2;

   logic [PAD_W-1:0] rad_w  [OUT_W];
   logic [REM_W-1:0] rem_w  [OUT_W];
   logic [OUT_W-1:0] root_w [OUT_W+1];

   assign rad_w[0]  = PAD_W'(rad_i);
   assign rem_w[0]  = '0;
   assign root_w[0] = '0;

   // one result bit per stage, restoring method
   for (genvar s = 0; s < OUT_W; s++) begin : g_stage
      logic [REM_W-1:0] shl;
      logic [REM_W-1:0] trial;
      logic             ge;
      logic [OUT_W-1:0] root_in;
      logic [OUT_W-1:0] root_ff;

      always_comb begin
         shl     = {rem_w[s][REM_W-3:0], rad_w[s][PAD_W-1 -: 2]};
         trial   = {root_w[s], 2'b01};
         ge      = (shl >= trial);
         root_in = {root_w[s][OUT_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff <= root_in;
         end
      end
      assign root_w[s+1] = root_ff;

      if (s < OUT_W - 1) begin : g_carry
         logic [REM_W-1:0] rem_in;
         logic [REM_W-1:0] rem_ff;
         logic [PAD_W-1:0] rad_ff;

         assign rem_in = ge ? (shl - trial) : shl;

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff <= rem_in;
               rad_ff <= rad_w[s] << 2;
            end
         end
         assign rem_w[s+1] = rem_ff;
         assign rad_w[s+1] = rad_ff;
      end
   end

   assign root_o = root_w[OUT_W];

endmodule
`default_nettype wire

/* rtl/core/pitat_heron.sv */
`default_nettype none
module pitat_heron
   import pitat_pkg::*;
#(
   parameter int FRAC_BITS = 4
) (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic signed [COORD_BITS-1:0] x0_i,
   input  wire logic signed [COORD_BITS-1:0] y0_i,
   input  wire logic signed [COORD_BITS-1:0] x1_i,
   input  wire logic signed [COORD_BITS-1:0] y1_i,
   input  wire logic signed [COORD_BITS-1:0] x2_i,
   input  wire logic signed [COORD_BITS-1:0] y2_i,
   output logic [area_w(FRAC_BITS)-1:0]      area_o
);

   localparam int C     = COORD_BITS;
   localparam int RAD_W = 2 * C + 1 + 2 * FRAC_BITS;
   localparam int L     = side_w(FRAC_BITS);
   localparam int P_W   = L + 1;
   localparam int MW    = 2 * P_W;
   localparam int PR_W  = 4 * P_W;

   // sides: 0 = (v0,v1), 1 = (v1,v2), 2 = (v0,v2)
   logic signed [C-1:0] sx0 [3];
   logic signed [C-1:0] sy0 [3];
   logic signed [C-1:0] sx1 [3];
   logic signed [C-1:0] sy1 [3];

   assign sx0[0] = x0_i; assign sy0[0] = y0_i; assign sx1[0] = x1_i; assign sy1[0] = y1_i;
   assign sx0[1] = x1_i; assign sy0[1] = y1_i; assign sx1[1] = x2_i; assign sy1[1] = y2_i;
   assign sx0[2] = x0_i; assign sy0[2] = y0_i; assign sx1[2] = x2_i; assign sy1[2] = y2_i;

   logic [L-1:0] side [3];

   for (genvar i = 0; i < 3; i++) begin : g_side
      logic signed [C:0] dx, dy;
      logic [C-1:0]      ux_in, uy_in, ux_ff, uy_ff;
      logic [2*C-1:0]    qx_ff, qy_ff;
      logic [RAD_W-1:0]  rad;

      always_comb begin
         dx    = {sx1[i][C-1], sx1[i]} - {sx0[i][C-1], sx0[i]};
         dy    = {sy1[i][C-1], sy1[i]} - {sy0[i][C-1], sy0[i]};
         ux_in = dx[C] ? C'(-dx) : dx[C-1:0];
         uy_in = dy[C] ? C'(-dy) : dy[C-1:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ux_ff <= ux_in;
            uy_ff <= uy_in;
            qx_ff <= ux_ff * ux_ff;
            qy_ff <= uy_ff * uy_ff;
         end
      end

      assign rad = (RAD_W'(qx_ff) + RAD_W'(qy_ff)) << (2 * FRAC_BITS);

      pitat_isqrt #(.IN_W(RAD_W)) u_sqrt (
         .clock  (clock),
         .en     (en),
         .rad_i  (rad),
         .root_o (side[i])
      );
   end

   logic [P_W-1:0]  p_in, p_ff, p2_ff;
   logic [L-1:0]    s_ff [3];
   logic [P_W-1:0]  m_in [3];
   logic [P_W-1:0]  m_ff [3];
   logic [2:0]      lt;
   logic            neg_ff, neg2_ff, neg3_ff;
   logic [MW-1:0]   x_ff, y_ff;
   logic [MW+P_W-1:0] lo_ff, hi_ff;
   logic [PR_W-1:0] prod, prod_in, prod_ff;

   assign p_in = P_W'((L+2)'(side[0]) + (L+2)'(side[1]) + (L+2)'(side[2]) >> 1);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lt[i]   = (p_ff < P_W'(s_ff[i]));
         m_in[i] = lt[i] ? (P_W'(s_ff[i]) - p_ff) : (p_ff - P_W'(s_ff[i]));
      end
   end

   // product split in half-width partials over two stages
   assign prod    = PR_W'(lo_ff) + (PR_W'(hi_ff) << P_W);
   assign prod_in = (neg3_ff && (prod != '0)) ? '0 : prod;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff    <= p_in;
         s_ff    <= side;
         p2_ff   <= p_ff;
         m_ff    <= m_in;
         neg_ff  <= ^lt;
         x_ff    <= p2_ff * m_ff[0];
         y_ff    <= m_ff[1] * m_ff[2];
         neg2_ff <= neg_ff;
         lo_ff   <= x_ff * y_ff[P_W-1:0];
         hi_ff   <= x_ff * y_ff[MW-1:P_W];
         neg3_ff <= neg2_ff;
         prod_ff <= prod_in;
      end
   end

   // neg3_ff carries the sign alongside lo/hi into the clamp
   pitat_isqrt #(.IN_W(PR_W)) u_area (
      .clock  (clock),
      .en     (en),
      .rad_i  (prod_ff),
      .root_o (area_o)
   );

endmodule
`default_nettype wire

/* rtl/core/point_in_triangle_area_test_core.sv */
// Point-in-triangle hit test by Heron area comparison.
// Configuration: csr_we/csr_index/csr_wdata write the three vertices
// (indexes 0..5) and the area tolerance (index 6); write only while idle.
// Requests: one query point per req transaction (req_valid/req_ready).
// Responses: one rsp transaction per request, in order, carrying the
// inside flag, the whole triangle area and the summed sub-triangle area.
// Throughput: one transaction per cycle while the output buffer has room.
// Pipeline: each Heron lane runs two bit-per-stage square root
// pipelines in turn (side lengths, then area); a sum stage and a
// compare stage follow, then the output register.
// Stall: a two-entry output buffer sits after the pipeline; while one
// response waits, requests are still taken. When both entries are full
// req_ready drops and the whole pipeline freezes, nothing lost.
// Reset: synchronous, clears valids, the output buffer, vertices to 0 and
// tolerance to 5.
`default_nettype none
module point_in_triangle_area_test_core
   import pitat_pkg::*;
#(
   parameter int FRAC_BITS = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_payload_type       req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_payload_type            rsp_payload,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AREA_W = area_w(FRAC_BITS);
   localparam int ASUM_W = AREA_W + 2;
   localparam int HL     = heron_lat(FRAC_BITS);
   localparam int NSTG   = HL + 2;

   // ---- configuration registers ----
   logic signed [COORD_BITS-1:0] vax_ff, vay_ff, vbx_ff, vby_ff, vcx_ff, vcy_ff;
   logic [TOL_W-1:0]             tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vax_ff <= '0; vay_ff <= '0;
         vbx_ff <= '0; vby_ff <= '0;
         vcx_ff <= '0; vcy_ff <= '0;
         tol_ff <= TOL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VERTEX_A_X: vax_ff <= csr_wdata;
            CSR_VERTEX_A_Y: vay_ff <= csr_wdata;
            CSR_VERTEX_B_X: vbx_ff <= csr_wdata;
            CSR_VERTEX_B_Y: vby_ff <= csr_wdata;
            CSR_VERTEX_C_X: vcx_ff <= csr_wdata;
            CSR_VERTEX_C_Y: vcy_ff <= csr_wdata;
            CSR_AREA_TOL:   tol_ff <= csr_wdata[TOL_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // ---- pipeline control ----
   // Whole pipeline advances together; it only freezes when the output
   // buffer holds two responses.
   logic            en;
   logic            skid_v_ff;
   logic [NSTG-1:0] vld_ff, vld_in;

   assign en        = !skid_v_ff;
   assign req_ready = en;
   assign vld_in    = {vld_ff[NSTG-2:0], req_valid & req_ready};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // ---- four Heron lanes: whole triangle, ABP, BCP, CAP ----
   logic [AREA_W-1:0] area [4];

   pitat_heron #(.FRAC_BITS(FRAC_BITS)) u_whole (
      .clock(clock), .en(en),
      .x0_i(vax_ff), .y0_i(vay_ff), .x1_i(vbx_ff), .y1_i(vby_ff),
      .x2_i(vcx_ff), .y2_i(vcy_ff), .area_o(area[0])
   );

   pitat_heron #(.FRAC_BITS(FRAC_BITS)) u_abp (
      .clock(clock), .en(en),
      .x0_i(vax_ff), .y0_i(vay_ff), .x1_i(vbx_ff), .y1_i(vby_ff),
      .x2_i(req_payload.point_x), .y2_i(req_payload.point_y), .area_o(area[1])
   );

   pitat_heron #(.FRAC_BITS(FRAC_BITS)) u_bcp (
      .clock(clock), .en(en),
      .x0_i(vbx_ff), .y0_i(vby_ff), .x1_i(vcx_ff), .y1_i(vcy_ff),
      .x2_i(req_payload.point_x), .y2_i(req_payload.point_y), .area_o(area[2])
   );

   pitat_heron #(.FRAC_BITS(FRAC_BITS)) u_cap (
      .clock(clock), .en(en),
      .x0_i(vcx_ff), .y0_i(vcy_ff), .x1_i(vax_ff), .y1_i(vay_ff),
      .x2_i(req_payload.point_x), .y2_i(req_payload.point_y), .area_o(area[3])
   );

   // ---- sum stage ----
   logic [ASUM_W-1:0] asum_in, asum_ff;
   logic [AREA_W-1:0] whole_ff;

   assign asum_in = ASUM_W'(area[1]) + ASUM_W'(area[2]) + ASUM_W'(area[3]);

   always_ff @(posedge clock) begin
      if (en) begin
         asum_ff  <= asum_in;
         whole_ff <= area[0];
      end
   end

   // ---- compare stage: integer parts, full precision ----
   logic [ASUM_W-1:0] wi, si, dif;
   rsp_payload_type   res_in, res_ff;

   always_comb begin
      wi  = ASUM_W'(whole_ff >> (2 * FRAC_BITS));
      si  = asum_ff >> (2 * FRAC_BITS);
      dif = (wi >= si) ? (wi - si) : (si - wi);
      res_in.inside_res    = (dif <= ASUM_W'(tol_ff));
      res_in.triangle_area = wi[TRI_W-1:0];
      res_in.summed_area   = si[SUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   // ---- output register plus skid entry ----
   logic            push, out_free;
   logic            out_v_ff;
   rsp_payload_type out_ff, skid_ff;

   assign push     = vld_ff[NSTG-1] & en;
   assign out_free = !out_v_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_v_ff) begin
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= push;
         end
      end else if (push) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_v_ff ? skid_ff : res_ff;
      end else if (push) begin
         skid_ff <= res_ff;
      end
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_payload = out_ff;

endmodule
`default_nettype wire

/* rtl/core/pitat_chk.sv */
`default_nettype none
`include "point_in_triangle_area_test_core_defines.svh"
module pitat_chk
   import pitat_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire req_payload_type       req_payload,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire rsp_payload_type       rsp_payload,
   input wire logic                  csr_we,
   input wire logic [CSR_IDX_W-1:0]  csr_index,
   input wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // stalled response holds
   `PITAT_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "rsp changed while stalled")

   // with no response pending, the buffer is empty, so requests flow
   `PITAT_ASSERT_IMP(a_ready_idle, !rsp_valid, req_ready, "req_ready low with empty output")

   // back-pressure only after a refused response
   `PITAT_ASSERT_IMP(a_ready_fall, $fell(req_ready), rsp_valid && $past(rsp_valid && !rsp_ready), "req_ready fell without output stall")

endmodule

bind point_in_triangle_area_test_core pitat_chk u_pitat_chk (.*);
`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none
module tb;
   import pitat_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 4;
   // unmapped register slot, writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam int PIPE_DEPTH = 3 * (COORD_BITS + FRAC) + 14;
   localparam int STALL_LIMIT = 20000;

   // Scoreboard: keeps its own copy of the vertex/tolerance registers and a
   // queue of expected responses, one per accepted request, in order.
   class area_scoreboard;
      logic signed [COORD_BITS-1:0] vx[3], vy[3];
      logic [TOL_W-1:0] tolerance;
      rsp_payload_type  pending[$];
      int errors;

      function new();
         foreach (vx[i]) begin
            vx[i] = '0;
            vy[i] = '0;
         end
         tolerance = TOL_RESET;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_VERTEX_A_X: vx[0] = val;
            CSR_VERTEX_A_Y: vy[0] = val;
            CSR_VERTEX_B_X: vx[1] = val;
            CSR_VERTEX_B_Y: vy[1] = val;
            CSR_VERTEX_C_X: vx[2] = val;
            CSR_VERTEX_C_Y: vy[2] = val;
            CSR_AREA_TOL:   tolerance = val[TOL_W-1:0];
            default: ;
         endcase
      endfunction

      // bit-serial integer square root, floor
      function logic [63:0] int_sqrt(logic [127:0] n);
         logic [63:0] r, c;
         r = '0;
         for (int i = 63; i >= 0; i--) begin
            c = r | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= n)
               r = c;
         end
         return r;
      endfunction

      // side length in Q.4
      function logic [63:0] side_len(longint x0, longint y0, longint x1, longint y1);
         longint dx, dy;
         logic [63:0] ux, uy;
         dx = x1 - x0;
         dy = y1 - y0;
         ux = dx < 0 ? -dx : dx;
         uy = dy < 0 ? -dy : dy;
         return int_sqrt({64'd0, (ux * ux + uy * uy) << (2 * FRAC)});
      endfunction

      // Heron area in Q.8; negative product (truncation) clamps to zero
      function logic [63:0] heron_area(longint x0, longint y0, longint x1, longint y1,
                                       longint x2, longint y2);
         logic [63:0]  s[3];
         logic [63:0]  semi, m;
         logic [127:0] prod;
         bit neg;
         s[0] = side_len(x0, y0, x1, y1);
         s[1] = side_len(x1, y1, x2, y2);
         s[2] = side_len(x0, y0, x2, y2);
         semi = (s[0] + s[1] + s[2]) >> 1;
         prod = {64'd0, semi};
         neg = 0;
         for (int i = 0; i < 3; i++) begin
            if (semi >= s[i])
               m = semi - s[i];
            else begin
               m = s[i] - semi;
               neg = !neg;
            end
            prod = prod * {64'd0, m};
         end
         if (neg && prod != 0)
            return '0;
         return int_sqrt(prod);
      endfunction

      function void note_request(req_payload_type req);
         longint ax, ay, bx, by, cx, cy, px, py;
         logic [63:0] whole, total, diff;
         rsp_payload_type exp_rsp;
         ax = vx[0]; ay = vy[0];
         bx = vx[1]; by = vy[1];
         cx = vx[2]; cy = vy[2];
         px = req.point_x; py = req.point_y;
         whole = heron_area(ax, ay, bx, by, cx, cy) >> (2 * FRAC);
         total = (heron_area(ax, ay, bx, by, px, py) + heron_area(bx, by, cx, cy, px, py)
                  + heron_area(cx, cy, ax, ay, px, py)) >> (2 * FRAC);
         diff = whole >= total ? whole - total : total - whole;
         exp_rsp.inside_res    = diff <= {56'd0, tolerance};
         exp_rsp.triangle_area = whole[TRI_W-1:0];
         exp_rsp.summed_area   = total[SUM_W-1:0];
         pending.push_back(exp_rsp);
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type exp_rsp;
         if (pending.size() == 0) begin
            errors++;
            $error("unexpected response %p", got);
            return;
         end
         exp_rsp = pending.pop_front();
         if (got.inside_res !== exp_rsp.inside_res) begin
            errors++;
            $error("inside_res: expected %0d, got %0d", exp_rsp.inside_res, got.inside_res);
         end
         if (got.triangle_area !== exp_rsp.triangle_area) begin
            errors++;
            $error("triangle_area: expected %0d, got %0d",
                   exp_rsp.triangle_area, got.triangle_area);
         end
         if (got.summed_area !== exp_rsp.summed_area) begin
            errors++;
            $error("summed_area: expected %0d, got %0d", exp_rsp.summed_area, got.summed_area);
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   area_scoreboard sb = new();
   bit gapless;        // set for a stretch with no idling on either side
   int quiet_cycles;   // cycles without any transaction, for the watchdog

   point_in_triangle_area_test_core #(.FRAC_BITS(FRAC)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // response side: random back-pressure, check every accepted transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_payload);
      rsp_ready <= gapless || $urandom_range(99) >= 26;
   end

   // watchdog on cycles with no transaction at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // one request transaction; outside gapless stretches valid may drop at random for a gap
   task automatic send_point(logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y);
      req_payload_type pt;
      pt.point_x = x;
      pt.point_y = y;
      req_payload <= pt;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(pt);
      if (!gapless && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 8) @(posedge clock);
   endtask

   // register writes back to back; write enable dropped once at the end
   task automatic load_triangle(int ax, int ay, int bx, int by, int cx, int cy, int tol);
      logic [CSR_IDX_W-1:0]  idx[7];
      logic [CSR_DATA_W-1:0] val[7];
      idx = '{CSR_VERTEX_A_X, CSR_VERTEX_A_Y, CSR_VERTEX_B_X, CSR_VERTEX_B_Y,
              CSR_VERTEX_C_X, CSR_VERTEX_C_Y, CSR_AREA_TOL};
      val = '{ax, ay, bx, by, cx, cy, tol};
      for (int i = 0; i < 7; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         sb.write_reg(idx[i], val[i]);
         @(posedge clock);
      end
      // spare slot: must leave everything untouched
      csr_index <= CSR_SPARE;
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic int rnd_coord();
      return $signed($urandom_range(4095)) - 2048;
   endfunction

   function automatic int clamp(int v);
      return v < -2048 ? -2048 : (v > 2047 ? 2047 : v);
   endfunction

   // mostly points inside the hull (barycentric), some near it, some anywhere
   task automatic random_points(int n);
      int w0, w1, w2, kind, x, y;
      for (int k = 0; k < n; k++) begin
         kind = $urandom_range(99);
         if (kind < 50) begin
            w0 = $urandom_range(256);
            w1 = $urandom_range(256 - w0);
            w2 = 256 - w0 - w1;
            x = (w0 * sb.vx[0] + w1 * sb.vx[1] + w2 * sb.vx[2]) / 256;
            y = (w0 * sb.vy[0] + w1 * sb.vy[1] + w2 * sb.vy[2]) / 256;
         end else if (kind < 80) begin
            x = clamp(sb.vx[$urandom_range(2)] + $signed($urandom_range(64)) - 32);
            y = clamp(sb.vy[$urandom_range(2)] + $signed($urandom_range(64)) - 32);
         end else begin
            x = rnd_coord();
            y = rnd_coord();
         end
         send_point(x, y);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      gapless = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset registers: every vertex at the origin, triangle degenerate
      send_point(0, 0);
      send_point(-2048, -2048);
      send_point(2047, 2047);
      send_point(-2048, 2047);
      drain();

      // widest triangle, zero tolerance; corners, centre and far points
      load_triangle(-2048, -2048, 2047, -2048, -2048, 2047, 0);
      send_point(-2048, -2048);
      send_point(2047, -2048);
      send_point(-2048, 2047);
      send_point(0, 0);
      send_point(2047, 2047);
      send_point(-1000, -1000);
      send_point(0, -2048);
      send_point(-2048, 2047);
      drain();

      // collinear vertices: degenerate area, full tolerance
      load_triangle(-100, -100, 0, 0, 100, 100, 255);
      send_point(50, 50);
      send_point(50, -50);
      send_point(2047, -2048);
      random_points(60);
      drain();

      // random phases, tolerance 0 first, 255 last, random between; one gapless
      for (int ph = 0; ph < 8; ph++) begin
         load_triangle(rnd_coord(), rnd_coord(), rnd_coord() / (ph + 1), rnd_coord(),
                       rnd_coord() / (ph + 1), rnd_coord() / (ph + 1),
                       ph == 0 ? 0 : (ph == 7 ? 255 : $urandom_range(255)));
         gapless = (ph == 3);
         random_points(72);
         if (ph == 5) begin
            // hold the sender until every outstanding response is back
            req_valid <= 1'b0;
            while (sb.pending.size() != 0) @(posedge clock);
         end
         random_points(72);
         gapless = 0;
         drain();
      end

      // tiny triangle, where truncation can make the product negative
      load_triangle(1, 1, 2, 1, 1, 2, 1);
      random_points(120);
      drain();

      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire

/* files.f */
+incdir+rtl/core
rtl/core/pitat_pkg.sv
rtl/core/pitat_isqrt.sv
rtl/core/pitat_heron.sv
rtl/core/point_in_triangle_area_test_core.sv
rtl/core/pitat_chk.sv
tb/sv/tb.sv
